// ----- rtl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the positional insert sequence store
// Beat layouts, status codes, sequencer states and storage sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

   localparam int CAPACITY = 1024;
   localparam int POS_W    = 11;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_POS  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                  kind;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      status_type                status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_WRITE,
      ST_QUERY,
      ST_QREAD
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/pss_ram.sv -----
// ----------------------------------------------------------------------------
// pss_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/positional_insert_sequence_store.sv -----
// ----------------------------------------------------------------------------
// positional_insert_sequence_store: ordered store with insert-after-position
// Keeps up to CAPACITY signed values in order; inserts and indexed queries.
// ----------------------------------------------------------------------------
// Each request beat yields one response beat. An insert at position p while n
// values are held moves the n-p later elements up one place, one element per
// cycle through the single write port of the element RAM, and then writes the
// new value; an append at the end moves nothing. A query first sets the RAM
// address, then takes the registered RAM read. Requests rejected as full or
// out of range answer in the cycle after they are accepted. One request is
// in work at a time; req_stall stays high until its response beat is in the
// output register and is not stalled there. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_sequence_store (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire pss_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      pss_pkg::rsp_type rsp_data
);

   import pss_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                moved_ff, moved_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    pos_dec;
   logic [CNT_W-1:0]    cnt_dec;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wa;
   logic [DATA_W-1:0]   ram_wd;
   logic [ADDR_W-1:0]   ram_ra;
   logic [DATA_W-1:0]   ram_rd;

   pss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_ext = CMP_W'(req_data.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_dec = pos_ext - CMP_W'(1);
   assign cnt_dec = count_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      addr_ff  <= addr_in;
      moved_ff <= moved_in;
      val_ff   <= val_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      moved_in     = moved_ff;
      val_in       = val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_wa       = addr_ff;
      ram_wd       = ram_rd;
      ram_ra       = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == KIND_INSERT) begin
                  priority if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_in       = '{read_value: '0, status: STAT_FULL};
                     rsp_valid_in = 1'b1;
                  end else if (pos_ext > cnt_ext) begin
                     rsp_in       = '{read_value: '0, status: STAT_POS};
                     rsp_valid_in = 1'b1;
                  end else begin
                     addr_in  = pos_ext[ADDR_W-1:0];
                     val_in   = req_data.value;
                     idx_in   = cnt_dec[ADDR_W-1:0];
                     moved_in = 1'b0;
                     if (pos_ext == cnt_ext) begin
                        state_in = ST_WRITE;
                     end else begin
                        state_in = ST_SHIFT;
                     end
                  end
               end else begin
                  if (pos_ext == '0 || pos_ext > cnt_ext) begin
                     rsp_in       = '{read_value: '0, status: STAT_POS};
                     rsp_valid_in = 1'b1;
                  end else begin
                     addr_in  = pos_dec[ADDR_W-1:0];
                     state_in = ST_QUERY;
                  end
               end
            end
         end
         ST_SHIFT: begin
            // read one element down, write the previous one a place up
            ram_ra   = idx_ff;
            ram_we   = moved_ff;
            ram_wa   = idx_ff + ADDR_W'(2);
            moved_in = 1'b1;
            if (idx_ff == addr_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff - ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            ram_we   = 1'b1;
            ram_wa   = addr_ff + ADDR_W'(1);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ram_we       = 1'b1;
            ram_wa       = addr_ff;
            ram_wd       = val_ff;
            count_in     = count_ff + CNT_W'(1);
            rsp_in       = '{read_value: '0, status: STAT_OK};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_QUERY: begin
            ram_ra   = addr_ff;
            state_in = ST_QREAD;
         end
         ST_QREAD: begin
            rsp_in       = '{read_value: ram_rd, status: STAT_OK};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
